[src/tdcs_pkg.sv]
package tdcs_pkg;

    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 240;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_FILL  = 2'd1;
    localparam logic [1:0] OP_PIXEL = 2'd2;
    localparam logic [1:0] OP_CHAR  = 2'd3;
    localparam logic [1:0] OP_IDLE  = 2'd0;

    localparam logic [7:0] CMD_COL_ADDR = 8'h2A;
    localparam logic [7:0] CMD_ROW_ADDR = 8'h2B;
    localparam logic [7:0] CMD_MEM_WR   = 8'h2C;

    localparam logic [3:0] STEP_COL_CMD  = 4'd0;
    localparam logic [3:0] STEP_XS_HI    = 4'd1;
    localparam logic [3:0] STEP_XS_LO    = 4'd2;
    localparam logic [3:0] STEP_XE_HI    = 4'd3;
    localparam logic [3:0] STEP_XE_LO    = 4'd4;
    localparam logic [3:0] STEP_ROW_CMD  = 4'd5;
    localparam logic [3:0] STEP_YS_HI    = 4'd6;
    localparam logic [3:0] STEP_YS_LO    = 4'd7;
    localparam logic [3:0] STEP_YE_HI    = 4'd8;
    localparam logic [3:0] STEP_YE_LO    = 4'd9;
    localparam logic [3:0] STEP_WR_CMD   = 4'd10;
    localparam logic [3:0] STEP_COLOR    = 4'd11;

    typedef struct packed {
        logic        load;
        logic        next;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  char_code;
        logic [3:0]  scale;
    } t_walk_ctl;

    typedef struct packed {
        logic        searching;
        logic        hit;
        logic        miss;
        logic [15:0] px;
        logic [15:0] py;
        logic        dot;
    } t_walk_stat;

    // Five column bytes, column 0 in the low byte; bit n of a column is row n.
    function automatic logic [39:0] glyph_bits(input logic [7:0] ch);
        logic [39:0] g;
        case (ch)
            8'h30: g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
            8'h31: g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
            8'h32: g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
            8'h33: g = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
            8'h34: g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
            8'h35: g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
            8'h36: g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
            8'h37: g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
            8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            8'h39: g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
            8'h41: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
            8'h42: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
            8'h43: g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
            8'h44: g = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
            8'h45: g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
            8'h46: g = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
            8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
            8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
            8'h4B: g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
            8'h4D: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
            8'h4E: g = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
            8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
            8'h50: g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
            8'h52: g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
            8'h53: g = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
            8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
            8'h55: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
            8'h59: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
            8'h3A: g = {8'h00, 8'h36, 8'h00, 8'h36, 8'h00};
            8'h25: g = {8'h63, 8'h64, 8'h08, 8'h13, 8'h63};
            8'h2D: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
            8'h2F: g = {8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

[src/tdcs_if.sv]
interface tdcs_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [15:0] fore_color;
    logic [15:0] back_color;
    logic [7:0]  char_code;
    logic [3:0]  scale;

    modport source (output valid, opcode, pos_x, pos_y, rect_width, rect_height,
                    fore_color, back_color, char_code, scale, input ready);
    modport sink (input valid, opcode, pos_x, pos_y, rect_width, rect_height,
                  fore_color, back_color, char_code, scale, output ready);
endinterface

interface tdcs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_data;
    logic       release_select;
    logic       op_last;

    modport source (output valid, out_byte, is_data, release_select, op_last,
                    input ready);
    modport sink (input valid, out_byte, is_data, release_select, op_last,
                  output ready);
endinterface

[src/tdcs_glyph_walk.sv]
module tdcs_glyph_walk #(
    parameter int SCREEN_WIDTH  = tdcs_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tdcs_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tdcs_pkg::t_walk_ctl   i_ctl,
    output tdcs_pkg::t_walk_stat  o_stat
);

    logic        r_search;
    logic [15:0] r_bx, r_by;
    logic [7:0]  r_char;
    logic [3:0]  r_scale;
    logic [2:0]  r_col, r_row;
    logic [3:0]  r_dx, r_dy;

    logic [2:0]  n_col, n_row;
    logic [3:0]  n_dx, n_dy;
    logic [15:0] px, py;
    logic [39:0] bits;
    logic        on_screen, done, hit, miss;

    // Walk order: vertical subpixel fastest, then horizontal, then row, then column.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_dx  = r_dx;
        n_dy  = r_dy + 4'd1;
        if (n_dy >= r_scale) begin
            n_dy = '0;
            n_dx = r_dx + 4'd1;
            if (n_dx >= r_scale) begin
                n_dx = '0;
                if (r_row < 3'd6) begin
                    n_row = r_row + 3'd1;
                end else begin
                    n_row = '0;
                    n_col = r_col + 3'd1;
                end
            end
        end
    end

    assign px = r_bx + ({13'd0, r_col} * {12'd0, r_scale}) + 16'(r_dx);
    assign py = r_by + ({13'd0, r_row} * {12'd0, r_scale}) + 16'(r_dy);
    assign on_screen = (px < 16'(SCREEN_WIDTH)) && (py < 16'(SCREEN_HEIGHT));
    assign done = (r_scale == 4'd0) || (r_col >= 3'd5);
    assign hit  = r_search && !done && on_screen;
    assign miss = r_search && done;
    assign bits = tdcs_pkg::glyph_bits(r_char);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search <= 1'b0;
        end else if (i_ctl.load || i_ctl.next) begin
            r_search <= 1'b1;
        end else if (hit || miss) begin
            r_search <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bx    <= i_ctl.x;
            r_by    <= i_ctl.y;
            r_char  <= i_ctl.char_code;
            r_scale <= i_ctl.scale;
            r_col   <= '0;
            r_row   <= '0;
            r_dx    <= '0;
            r_dy    <= '0;
        end else if (i_ctl.next || (r_search && !done && !on_screen)) begin
            r_col <= n_col;
            r_row <= n_row;
            r_dx  <= n_dx;
            r_dy  <= n_dy;
        end
    end

    assign o_stat.searching = r_search;
    assign o_stat.hit       = hit;
    assign o_stat.miss      = miss;
    assign o_stat.px        = px;
    assign o_stat.py        = py;
    assign o_stat.dot       = (r_col < 3'd5) ? bits[{r_col, r_row}] : 1'b0;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(hit && miss))
        else $error("glyph walk hit and miss together");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hit || miss) && !i_ctl.load && !i_ctl.next |=> !r_search)
        else $error("glyph walk kept searching after a result");

endmodule

[src/tft_draw_command_sequencer.sv]
// Channel   | Direction | Beat contents
// i_cmd     | in        | opcode, position, size, colors, character, scale
// o_byte    | out       | serial byte, data/command flag, select release, last flag
//
// A tick beat yields its byte in the cycle after it is taken; start beats yield none.
// Window and color bytes flow at one beat per cycle while ticks arrive and o_byte is ready.
// A character searches one glyph subpixel per cycle for the next on-screen pixel;
// i_cmd.ready is low during that search.
// The last color byte of a glyph pixel waits in the output register until the search
// ends, since its last flag depends on it.
// Reset is synchronous, active low, and leaves the sequencer idle.
module tft_draw_command_sequencer #(
    parameter int SCREEN_WIDTH  = tdcs_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tdcs_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdcs_cmd_if.sink    i_cmd,
    tdcs_byte_if.source o_byte
);

    localparam int CW    = $clog2(SCREEN_WIDTH + 1);
    localparam int CH    = $clog2(SCREEN_HEIGHT + 1);
    localparam int PIX_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT + 1);

    logic [1:0]       r_active, n_active;
    logic [3:0]       r_step, n_step;
    logic [15:0]      r_xs, r_ys, r_xe, r_ye, n_xs, n_ys, n_xe, n_ye;
    logic [PIX_W-1:0] r_pix, n_pix;
    logic [15:0]      r_fg, r_bg, n_fg, n_bg;
    logic             r_phase, n_phase, r_pend, n_pend;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_byte, n_byte;
    logic             r_data, n_data, r_rel, n_rel, r_last, n_last;

    tdcs_pkg::t_walk_ctl  walk_ctl;
    tdcs_pkg::t_walk_stat walk;

    logic        cmd_acc, tick, start;
    logic [16:0] x_sum, y_sum;
    logic [15:0] w_clip, h_clip, color;
    logic [PIX_W-1:0] pix_dec;

    assign i_cmd.ready = !walk.searching && (!r_out_valid || o_byte.ready);
    assign cmd_acc = i_cmd.valid && i_cmd.ready;
    assign tick  = cmd_acc && (i_cmd.opcode == tdcs_pkg::OP_TICK) &&
                   (r_active != tdcs_pkg::OP_IDLE);
    assign start = cmd_acc && (i_cmd.opcode != tdcs_pkg::OP_TICK) &&
                   (r_active == tdcs_pkg::OP_IDLE);

    assign x_sum = {1'b0, i_cmd.pos_x} + ((i_cmd.opcode == tdcs_pkg::OP_PIXEL) ?
                   17'd1 : {1'b0, i_cmd.rect_width});
    assign y_sum = {1'b0, i_cmd.pos_y} + ((i_cmd.opcode == tdcs_pkg::OP_PIXEL) ?
                   17'd1 : {1'b0, i_cmd.rect_height});
    assign w_clip = (x_sum > 17'(SCREEN_WIDTH)) ? 16'(SCREEN_WIDTH) - i_cmd.pos_x :
                    16'(x_sum - {1'b0, i_cmd.pos_x});
    assign h_clip = (y_sum > 17'(SCREEN_HEIGHT)) ? 16'(SCREEN_HEIGHT) - i_cmd.pos_y :
                    16'(y_sum - {1'b0, i_cmd.pos_y});
    assign pix_dec = r_pix - PIX_W'(1);
    assign color = (r_active == tdcs_pkg::OP_CHAR && !walk.dot) ? r_bg : r_fg;

    always_comb begin
        walk_ctl.load      = start && (i_cmd.opcode == tdcs_pkg::OP_CHAR);
        walk_ctl.next      = 1'b0;
        walk_ctl.x         = i_cmd.pos_x;
        walk_ctl.y         = i_cmd.pos_y;
        walk_ctl.char_code = i_cmd.char_code;
        walk_ctl.scale     = i_cmd.scale;

        n_active = r_active;
        n_step   = r_step;
        n_xs = r_xs; n_ys = r_ys; n_xe = r_xe; n_ye = r_ye;
        n_pix = r_pix;
        n_fg = r_fg; n_bg = r_bg;
        n_phase = r_phase;
        n_pend  = r_pend;
        n_out_valid = r_out_valid && !o_byte.ready;
        n_byte = r_byte; n_data = r_data; n_rel = r_rel; n_last = r_last;

        if (start) begin
            n_fg = i_cmd.fore_color;
            n_bg = i_cmd.back_color;
            n_step = tdcs_pkg::STEP_COL_CMD;
            n_phase = 1'b0;
            if (i_cmd.opcode != tdcs_pkg::OP_CHAR &&
                    i_cmd.pos_x < 16'(SCREEN_WIDTH) && i_cmd.pos_y < 16'(SCREEN_HEIGHT)) begin
                n_active = i_cmd.opcode;
                n_xs = i_cmd.pos_x;
                n_ys = i_cmd.pos_y;
                n_xe = i_cmd.pos_x + w_clip - 16'd1;
                n_ye = i_cmd.pos_y + h_clip - 16'd1;
                n_pix = PIX_W'(w_clip[CW-1:0]) * PIX_W'(h_clip[CH-1:0]);
            end
        end

        if (tick) begin
            n_out_valid = 1'b1;
            n_data = 1'b1;
            n_rel  = 1'b0;
            n_last = 1'b0;
            n_byte = '0;
            case (r_step)
                tdcs_pkg::STEP_COL_CMD: begin
                    n_byte = tdcs_pkg::CMD_COL_ADDR; n_data = 1'b0; n_rel = 1'b1;
                end
                tdcs_pkg::STEP_XS_HI: n_byte = r_xs[15:8];
                tdcs_pkg::STEP_XS_LO: n_byte = r_xs[7:0];
                tdcs_pkg::STEP_XE_HI: n_byte = r_xe[15:8];
                tdcs_pkg::STEP_XE_LO: begin
                    n_byte = r_xe[7:0]; n_rel = 1'b1;
                end
                tdcs_pkg::STEP_ROW_CMD: begin
                    n_byte = tdcs_pkg::CMD_ROW_ADDR; n_data = 1'b0; n_rel = 1'b1;
                end
                tdcs_pkg::STEP_YS_HI: n_byte = r_ys[15:8];
                tdcs_pkg::STEP_YS_LO: n_byte = r_ys[7:0];
                tdcs_pkg::STEP_YE_HI: n_byte = r_ye[15:8];
                tdcs_pkg::STEP_YE_LO: begin
                    n_byte = r_ye[7:0]; n_rel = 1'b1;
                end
                tdcs_pkg::STEP_WR_CMD: begin
                    n_byte = tdcs_pkg::CMD_MEM_WR; n_data = 1'b0; n_rel = 1'b1;
                    if (r_active == tdcs_pkg::OP_FILL && r_pix == '0) begin
                        n_last = 1'b1;
                        n_active = tdcs_pkg::OP_IDLE;
                    end
                end
                default: begin
                    if (!r_phase) begin
                        n_byte = color[15:8];
                        n_phase = 1'b1;
                    end else begin
                        n_byte = color[7:0];
                        n_phase = 1'b0;
                        if (r_active == tdcs_pkg::OP_FILL) begin
                            n_pix = pix_dec;
                            if (pix_dec == '0) begin
                                n_rel = 1'b1; n_last = 1'b1;
                                n_active = tdcs_pkg::OP_IDLE;
                            end
                        end else if (r_active == tdcs_pkg::OP_PIXEL) begin
                            n_rel = 1'b1; n_last = 1'b1;
                            n_active = tdcs_pkg::OP_IDLE;
                        end else begin
                            // Hold the beat until the walk finds the next pixel or runs out.
                            n_rel = 1'b1;
                            n_out_valid = 1'b0;
                            n_pend = 1'b1;
                            walk_ctl.next = 1'b1;
                        end
                    end
                end
            endcase
            if (r_step < tdcs_pkg::STEP_COLOR) n_step = r_step + 4'd1;
            if (n_active == tdcs_pkg::OP_IDLE) n_step = tdcs_pkg::STEP_COL_CMD;
        end

        if (walk.hit) begin
            n_active = tdcs_pkg::OP_CHAR;
            n_step = tdcs_pkg::STEP_COL_CMD;
            n_phase = 1'b0;
            n_xs = walk.px; n_xe = walk.px;
            n_ys = walk.py; n_ye = walk.py;
        end else if (walk.miss) begin
            n_active = tdcs_pkg::OP_IDLE;
            n_step = tdcs_pkg::STEP_COL_CMD;
            n_last = 1'b1;
        end
        if ((walk.hit || walk.miss) && r_pend) begin
            n_pend = 1'b0;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= tdcs_pkg::OP_IDLE;
            r_step      <= tdcs_pkg::STEP_COL_CMD;
            r_phase     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pix       <= '0;
        end else begin
            r_active    <= n_active;
            r_step      <= n_step;
            r_phase     <= n_phase;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_pix       <= n_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xs <= n_xs; r_ys <= n_ys; r_xe <= n_xe; r_ye <= n_ye;
        r_fg <= n_fg; r_bg <= n_bg;
        r_byte <= n_byte; r_data <= n_data; r_rel <= n_rel; r_last <= n_last;
    end

    tdcs_glyph_walk #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (walk_ctl),
        .o_stat  (walk)
    );

    assign o_byte.valid          = r_out_valid;
    assign o_byte.out_byte       = r_byte;
    assign o_byte.is_data        = r_data;
    assign o_byte.release_select = r_rel;
    assign o_byte.op_last        = r_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_pend |-> !r_out_valid)
        else $error("held glyph beat overlaps a valid output");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active == tdcs_pkg::OP_IDLE |-> r_step == tdcs_pkg::STEP_COL_CMD)
        else $error("idle with a nonzero byte step");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> r_step == tdcs_pkg::STEP_COLOR)
        else $error("low color byte pending outside the color phase");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> walk.searching)
        else $error("held glyph beat without a running search");

endmodule

[tb/sv/tdcs_scoreboard.sv]
`timescale 1ns / 100ps

class tdcs_scoreboard;
    localparam int SW = tdcs_pkg::DEF_SCREEN_WIDTH;
    localparam int SH = tdcs_pkg::DEF_SCREEN_HEIGHT;

    logic [1:0]  active_op;
    logic [3:0]  byte_step;
    logic [15:0] xs, ys, xe, ye;
    logic [23:0] pixels_left;
    logic [15:0] fg, bg;
    logic [7:0]  gch;
    int          gcol, grow, sdx, sdy, scl;
    bit          low_phase;
    logic [10:0] pending_bytes[$];
    int          errors;
    int          mismatches;

    function new();
        errors = 0;
        mismatches = 0;
        clear_state();
    endfunction

    function void clear_state();
        active_op = tdcs_pkg::OP_IDLE;
        byte_step = 0;
        xs = 0; ys = 0; xe = 0; ye = 0;
        pixels_left = 0;
        fg = 0; bg = 0; gch = 0;
        gcol = 0; grow = 0; sdx = 0; sdy = 0; scl = 0;
        low_phase = 0;
    endfunction

    function logic [7:0] font_column(logic [7:0] ch, int col);
        logic [7:0] c;
        c = 0;
        if (col < 5) begin
            case (ch)
                "0": c = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E} >> (8 * (4 - col));
                "1": c = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00} >> (8 * (4 - col));
                "2": c = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46} >> (8 * (4 - col));
                "3": c = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31} >> (8 * (4 - col));
                "4": c = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10} >> (8 * (4 - col));
                "5": c = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39} >> (8 * (4 - col));
                "6": c = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30} >> (8 * (4 - col));
                "7": c = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03} >> (8 * (4 - col));
                "8": c = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36} >> (8 * (4 - col));
                "9": c = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E} >> (8 * (4 - col));
                "A": c = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E} >> (8 * (4 - col));
                "B": c = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36} >> (8 * (4 - col));
                "C": c = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22} >> (8 * (4 - col));
                "D": c = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C} >> (8 * (4 - col));
                "E": c = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41} >> (8 * (4 - col));
                "F": c = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01} >> (8 * (4 - col));
                "H": c = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F} >> (8 * (4 - col));
                "I": c = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00} >> (8 * (4 - col));
                "K": c = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41} >> (8 * (4 - col));
                "M": c = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F} >> (8 * (4 - col));
                "N": c = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F} >> (8 * (4 - col));
                "O": c = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E} >> (8 * (4 - col));
                "P": c = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06} >> (8 * (4 - col));
                "R": c = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46} >> (8 * (4 - col));
                "S": c = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31} >> (8 * (4 - col));
                "T": c = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01} >> (8 * (4 - col));
                "U": c = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F} >> (8 * (4 - col));
                "Y": c = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07} >> (8 * (4 - col));
                ":": c = {8'h00, 8'h36, 8'h00, 8'h36, 8'h00} >> (8 * (4 - col));
                "%": c = {8'h63, 8'h13, 8'h08, 8'h64, 8'h63} >> (8 * (4 - col));
                "-": c = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08} >> (8 * (4 - col));
                "/": c = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02} >> (8 * (4 - col));
                default: c = 0;
            endcase
        end
        return c;
    endfunction

    function void walk_advance();
        sdy++;
        if (sdy < scl) return;
        sdy = 0;
        sdx++;
        if (sdx < scl) return;
        sdx = 0;
        grow++;
        if (grow < 7) return;
        grow = 0;
        gcol++;
    endfunction

    // Steps the glyph walk to the next dot that lands on screen.
    function bit walk_find(bit advance);
        logic [15:0] bx, by, px, py;
        if (scl == 0) return 0;
        bx = xs - 16'(gcol * scl) - 16'(sdx);
        by = ys - 16'(grow * scl) - 16'(sdy);
        if (advance) walk_advance();
        while (gcol < 5) begin
            px = bx + 16'(gcol * scl) + 16'(sdx);
            py = by + 16'(grow * scl) + 16'(sdy);
            if (px < SW && py < SH) begin
                xs = px; xe = px; ys = py; ye = py;
                return 1;
            end
            walk_advance();
        end
        return 0;
    endfunction

    function void note_command(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                               logic [15:0] w, logic [15:0] h, logic [15:0] fc,
                               logic [15:0] bc, logic [7:0] ch, logic [3:0] sc);
        int wi, hi;
        logic [7:0] b;
        bit dat, rel, lst;
        logic [15:0] color;
        logic [7:0] col_bits;
        if (op != tdcs_pkg::OP_TICK) begin
            if (active_op != tdcs_pkg::OP_IDLE) return;
            fg = fc; bg = bc; byte_step = 0; low_phase = 0;
            if (op == tdcs_pkg::OP_CHAR) begin
                gch = ch; scl = sc;
                gcol = 0; grow = 0; sdx = 0; sdy = 0;
                xs = x; ys = y;
                if (walk_find(0)) active_op = tdcs_pkg::OP_CHAR;
                return;
            end
            if (x >= SW || y >= SH) return;
            wi = w; hi = h;
            if (op == tdcs_pkg::OP_PIXEL) begin
                wi = 1; hi = 1;
            end
            if (x + wi > SW) wi = SW - x;
            if (y + hi > SH) hi = SH - y;
            xs = x; ys = y;
            xe = 16'(x + wi - 1);
            ye = 16'(y + hi - 1);
            pixels_left = 24'(wi * hi);
            active_op = op;
            return;
        end
        if (active_op == tdcs_pkg::OP_IDLE) return;
        b = 0; dat = 1; rel = 0; lst = 0;
        case (byte_step)
            tdcs_pkg::STEP_COL_CMD: begin
                b = tdcs_pkg::CMD_COL_ADDR; dat = 0; rel = 1;
            end
            tdcs_pkg::STEP_XS_HI: b = xs[15:8];
            tdcs_pkg::STEP_XS_LO: b = xs[7:0];
            tdcs_pkg::STEP_XE_HI: b = xe[15:8];
            tdcs_pkg::STEP_XE_LO: begin
                b = xe[7:0]; rel = 1;
            end
            tdcs_pkg::STEP_ROW_CMD: begin
                b = tdcs_pkg::CMD_ROW_ADDR; dat = 0; rel = 1;
            end
            tdcs_pkg::STEP_YS_HI: b = ys[15:8];
            tdcs_pkg::STEP_YS_LO: b = ys[7:0];
            tdcs_pkg::STEP_YE_HI: b = ye[15:8];
            tdcs_pkg::STEP_YE_LO: begin
                b = ye[7:0]; rel = 1;
            end
            tdcs_pkg::STEP_WR_CMD: begin
                b = tdcs_pkg::CMD_MEM_WR; dat = 0; rel = 1;
                if (active_op == tdcs_pkg::OP_FILL && pixels_left == 0) begin
                    lst = 1; active_op = tdcs_pkg::OP_IDLE;
                end
            end
            default: begin
                color = fg;
                col_bits = font_column(gch, gcol);
                if (active_op == tdcs_pkg::OP_CHAR && !col_bits[grow])
                    color = bg;
                if (!low_phase) begin
                    b = color[15:8]; low_phase = 1;
                end else begin
                    b = color[7:0]; low_phase = 0;
                    if (active_op == tdcs_pkg::OP_FILL) begin
                        pixels_left--;
                        if (pixels_left == 0) begin
                            rel = 1; lst = 1; active_op = tdcs_pkg::OP_IDLE;
                        end
                    end else if (active_op == tdcs_pkg::OP_PIXEL) begin
                        rel = 1; lst = 1; active_op = tdcs_pkg::OP_IDLE;
                    end else begin
                        rel = 1;
                        if (walk_find(1)) byte_step = 0;
                        else begin
                            lst = 1; active_op = tdcs_pkg::OP_IDLE;
                        end
                    end
                end
            end
        endcase
        if (byte_step < tdcs_pkg::STEP_COLOR &&
            !(byte_step == 0 && rel && dat && active_op == tdcs_pkg::OP_CHAR))
            byte_step++;
        if (active_op == tdcs_pkg::OP_IDLE) byte_step = 0;
        pending_bytes.push_back({b, dat, rel, lst});
    endfunction

    function void check_byte(logic [7:0] b, logic dat, logic rel, logic lst);
        logic [10:0] want;
        if (pending_bytes.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected byte %h d=%b r=%b l=%b", b, dat, rel, lst);
            return;
        end
        want = pending_bytes.pop_front();
        if (want !== {b, dat, rel, lst}) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("byte mismatch: want %h d=%b r=%b l=%b, got %h d=%b r=%b l=%b",
                         want[10:3], want[2], want[1], want[0], b, dat, rel, lst);
        end
    endfunction
endclass

[tb/sv/tb_tft_draw_command_sequencer.sv]
`timescale 1ns / 100ps

module tb_tft_draw_command_sequencer;

    logic i_clk = 0;
    logic i_rst_n = 0;
    tdcs_cmd_if  cmd_bus();
    tdcs_byte_if byte_bus();
    tdcs_scoreboard sb;
    int  stall_hold = 0;
    bit  calm = 0;
    bit  send_done = 0;

    tft_draw_command_sequencer i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd_bus.sink), .o_byte(byte_bus.source)
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    initial begin
        cmd_bus.valid = 0;
        cmd_bus.opcode = tdcs_pkg::OP_TICK;
        cmd_bus.pos_x = 0; cmd_bus.pos_y = 0;
        cmd_bus.rect_width = 0; cmd_bus.rect_height = 0;
        cmd_bus.fore_color = 0; cmd_bus.back_color = 0;
        cmd_bus.char_code = 0; cmd_bus.scale = 0;
        byte_bus.ready = 0;
    end

    // Sink side and checking: ready is redrawn every edge, beats sampled at it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (byte_bus.valid && byte_bus.ready)
                sb.check_byte(byte_bus.out_byte, byte_bus.is_data,
                              byte_bus.release_select, byte_bus.op_last);
            if (cmd_bus.valid && cmd_bus.ready)
                sb.note_command(cmd_bus.opcode, cmd_bus.pos_x, cmd_bus.pos_y,
                                cmd_bus.rect_width, cmd_bus.rect_height,
                                cmd_bus.fore_color, cmd_bus.back_color,
                                cmd_bus.char_code, cmd_bus.scale);
        end
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            byte_bus.ready <= 0;
        end else begin
            byte_bus.ready <= calm || ($urandom_range(99) >= 13);
        end
    end

    task automatic send_beat(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                             logic [15:0] w, logic [15:0] h, logic [15:0] fc,
                             logic [15:0] bc, logic [7:0] ch, logic [3:0] sc);
        while (!calm && $urandom_range(99) < 13) begin
            cmd_bus.valid <= 0;
            @(posedge i_clk);
        end
        cmd_bus.valid <= 1;
        cmd_bus.opcode <= op;
        cmd_bus.pos_x <= x; cmd_bus.pos_y <= y;
        cmd_bus.rect_width <= w; cmd_bus.rect_height <= h;
        cmd_bus.fore_color <= fc; cmd_bus.back_color <= bc;
        cmd_bus.char_code <= ch; cmd_bus.scale <= sc;
        do @(posedge i_clk); while (!cmd_bus.ready);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_beat(tdcs_pkg::OP_TICK, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic random_op();
        logic [1:0] op;
        logic [15:0] x, y, w, h;
        logic [7:0] ch;
        logic [7:0] known[8] = '{"0", "8", "A", "M", "%", "/", ":", "Y"};
        op = $urandom_range(3, 1);
        x = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(330));
        y = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(250));
        w = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(4));
        h = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(4));
        ch = ($urandom_range(3) == 0) ? 8'($urandom) : known[$urandom_range(7)];
        send_beat(op, x, y, w, h, $urandom, $urandom, ch, $urandom_range(2));
        // Mostly enough ticks to drain the operation, sometimes a premature start.
        if ($urandom_range(9) == 0) send_beat($urandom_range(3, 1), $urandom_range(40),
                                              $urandom_range(40), 2, 2, $urandom, $urandom,
                                              "5", 1);
        send_ticks($urandom_range(9) == 0 ? $urandom_range(20) : $urandom_range(40, 13));
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed part.
        send_ticks(2);
        send_beat(tdcs_pkg::OP_PIXEL, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0);
        send_beat(tdcs_pkg::OP_FILL, 5, 5, 3, 3, 0, 0, 0, 0);
        send_ticks(14);
        send_beat(tdcs_pkg::OP_PIXEL, 319, 239, 0, 0, 16'hA5C3, 0, 0, 0);
        send_ticks(13);
        send_beat(tdcs_pkg::OP_PIXEL, 320, 0, 0, 0, 16'h1234, 0, 0, 0);
        send_beat(tdcs_pkg::OP_FILL, 0, 240, 5, 5, 16'h1234, 0, 0, 0);
        send_beat(tdcs_pkg::OP_FILL, 318, 238, 16'hFFFF, 16'hFFFF, 16'h5AA5, 0, 0, 0);
        send_ticks(20);
        send_beat(tdcs_pkg::OP_FILL, 10, 10, 0, 7, 16'h0F0F, 0, 0, 0);
        send_ticks(12);
        send_beat(tdcs_pkg::OP_CHAR, 10, 10, 0, 0, 16'hFFFF, 16'h0000, "A", 0);
        send_beat(tdcs_pkg::OP_CHAR, 16'hFFFE, 238, 0, 0, 16'hF800, 16'h001F, "0", 2);
        send_ticks(400);
        send_beat(tdcs_pkg::OP_CHAR, 100, 100, 0, 0, 16'hF800, 16'h07E0, 8'hFF, 1);
        send_ticks(470);
        send_beat(tdcs_pkg::OP_CHAR, 200, 200, 0, 0, 16'h1111, 16'h2222, "%", 15);
        send_ticks(60);
        // Receiver holds off while the sender keeps ticking.
        stall_hold <= 300;
        send_ticks(80);
        for (int i = 0; i < 24; i++) begin
            calm = (i >= 8 && i < 14);
            random_op();
        end
        calm = 0;
        cmd_bus.valid <= 0;
        send_done = 1;
    end

    initial begin
        wait (send_done);
        while (sb.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("FAILURE");
        $finish;
    end
endmodule
